[src/swma_pkg.sv]
// Shared types and constants for the sliding window min and average block.
`timescale 1ns / 1ps
`default_nettype none
package swma_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MEAN_W   = 24;
	localparam int SUM_W    = 22;
	localparam int COUNT_W  = 7;
	localparam int FRAC_W   = 8;
	// scaled dividend: sum with the fraction bits appended
	localparam int DIVD_W   = SUM_W + FRAC_W;
	localparam int STEP_W   = 5;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_FIELD_W = MEAN_W + SAMPLE_W + SUM_W + COUNT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MEAN_W-1:0]   mean_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic        [COUNT_W-1:0]  count_t;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage
`default_nettype wire

[src/swma_div.sv]
// Bit-serial signed divider: (sum * 256) / count, truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none
module swma_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire swma_pkg::sum_t        dividend,
	input  wire swma_pkg::count_t      divisor,
	output swma_pkg::div_status_t      status,
	output swma_pkg::mean_t            quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic                                neg_q;
	logic [swma_pkg::STEP_W-1:0]         step_q;
	logic [swma_pkg::DIVD_W-1:0]         quo_q;
	logic [swma_pkg::COUNT_W-1:0]        rem_q;
	logic [swma_pkg::COUNT_W-1:0]        div_q;
	swma_pkg::mean_t                     quotient_q;

	logic signed [swma_pkg::DIVD_W-1:0]  scaled;
	logic [swma_pkg::DIVD_W-1:0]         mag;
	logic [swma_pkg::COUNT_W:0]          rem_sh;
	logic                                take;
	logic [swma_pkg::COUNT_W:0]          rem_diff;
	logic [swma_pkg::DIVD_W-1:0]         quo_next;
	logic [swma_pkg::DIVD_W-1:0]         quo_signed;

	// operand magnitude at start
	always_comb begin
		scaled = {dividend, {swma_pkg::FRAC_W{1'b0}}};
		mag    = scaled[swma_pkg::DIVD_W-1] ? (~scaled + 1'b1) : scaled;
	end

	// one restoring step per cycle
	always_comb begin
		rem_sh     = {rem_q, quo_q[swma_pkg::DIVD_W-1]};
		take       = (rem_sh >= {1'b0, div_q});
		rem_diff   = rem_sh - {1'b0, div_q};
		quo_next   = {quo_q[swma_pkg::DIVD_W-2:0], take};
		quo_signed = neg_q ? (~quo_next + 1'b1) : quo_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == swma_pkg::STEP_W'(swma_pkg::DIVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[swma_pkg::SUM_W-1];
		end else if (busy_q) begin
			quo_q <= quo_next;
			rem_q <= take ? rem_diff[swma_pkg::COUNT_W-1:0] : rem_sh[swma_pkg::COUNT_W-1:0];
			if (step_q == swma_pkg::STEP_W'(swma_pkg::DIVD_W - 1)) begin
				quotient_q <= quo_signed[swma_pkg::MEAN_W-1:0];
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quotient_q;

endmodule
`default_nettype wire

[src/sliding_window_min_and_average.sv]
// One sample at a time: after ST_UPD starts the bit-serial divider (30 steps),
// ST_SCAN runs the window-minimum rescan beside it; the result is registered for
// m_tvalid once both are done and the output register is free.
// A finished result waits in the output register while the next sample is taken.
// Reset (arst_n low, asynchronous) empties the window and the output register;
// ring contents are not cleared and are only read once written.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_min_and_average #(
	parameter int WINDOW = 10
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_tvalid,
	output logic                                  s_tready,
	input  wire  [swma_pkg::IN_TDATA_W-1:0]       s_tdata,  // [15:0] sample
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	// [23:0] mean_q8, [39:24] window_min, [61:40] window_sum, [68:62] held_count
	output logic [swma_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]              state_q;
	logic [IW-1:0]           write_slot_q;
	swma_pkg::count_t        fill_q;
	swma_pkg::sum_t          sum_q;
	swma_pkg::sample_t       sample_q;
	swma_pkg::sample_t       min_q;
	swma_pkg::count_t        scan_idx_q;
	logic                    rd_v_s1;
	swma_pkg::sample_t       rd_data_q;
	logic                    out_v_q;
	logic [swma_pkg::OUT_TDATA_W-1:0] out_data_q;

	swma_pkg::sample_t       ring [WINDOW];

	logic                    full;
	swma_pkg::sum_t          sum_next;
	swma_pkg::count_t        fill_next;
	logic [IW-1:0]           rd_addr;
	logic                    scan_issue;
	logic                    scan_done;
	logic                    out_free;
	logic                    finish;
	logic                    div_start;
	swma_pkg::div_status_t   div_st;
	swma_pkg::mean_t         div_quo;
	swma_pkg::sample_t       min_final;

	// window update arithmetic
	always_comb begin
		full      = (fill_q >= swma_pkg::COUNT_W'(WINDOW));
		sum_next  = sum_q - (full ? swma_pkg::SUM_W'(rd_data_q) : '0)
		            + swma_pkg::SUM_W'(sample_q);
		fill_next = full ? fill_q : (fill_q + 1'b1);
	end

	// single read port: oldest slot while idle, scan index while scanning
	always_comb begin
		rd_addr    = (state_q == ST_SCAN) ? scan_idx_q[IW-1:0] : write_slot_q;
		scan_issue = (state_q == ST_SCAN) && (scan_idx_q < fill_q);
		scan_done  = (scan_idx_q == fill_q) && !rd_v_s1;
		out_free   = !out_v_q || m_tready;
		finish     = (state_q == ST_SCAN) && scan_done && div_st.done && !div_st.busy
		             && out_free;
		div_start  = (state_q == ST_UPD);
		min_final  = min_q;
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			ring[write_slot_q] <= sample_q;
		end
		rd_data_q <= ring[rd_addr];
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			scan_idx_q   <= '0;
			rd_v_s1      <= 1'b0;
		end else begin
			rd_v_s1 <= scan_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q        <= sum_next;
					fill_q       <= fill_next;
					write_slot_q <= (write_slot_q == IW'(WINDOW - 1)) ? '0
					                : (write_slot_q + 1'b1);
					scan_idx_q   <= '0;
					state_q      <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample capture and running minimum compare
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			sample_q <= s_tdata[swma_pkg::SAMPLE_W-1:0];
		end
		if (state_q == ST_UPD) begin
			min_q <= sample_q;
		end else if (rd_v_s1 && (rd_data_q < min_q)) begin
			min_q <= rd_data_q;
		end
	end

	swma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (fill_next),
		.status   (div_st),
		.quotient (div_quo)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (finish) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= {{(swma_pkg::OUT_TDATA_W - swma_pkg::OUT_FIELD_W){1'b0}},
			               fill_q, sum_q, min_final, div_quo};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

[src/swma_checker.sv]
// Port-level checks for the sliding window min and average block, with bind.
`timescale 1ns / 1ps
`default_nettype none
module swma_checker #(
	parameter int WINDOW = 10
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [swma_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic signed [swma_pkg::MEAN_W-1:0]   mean_f;
	logic signed [swma_pkg::SAMPLE_W-1:0] min_f;
	logic [swma_pkg::COUNT_W-1:0]         cnt_f;
	logic signed [swma_pkg::MEAN_W-1:0]   min_scaled;

	assign mean_f     = m_tdata[23:0];
	assign min_f      = m_tdata[39:24];
	assign cnt_f      = m_tdata[68:62];
	assign min_scaled = {min_f, {swma_pkg::FRAC_W{1'b0}}};

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one sample in flight: not ready right after a transaction
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a sample while busy");

	// count stays inside the window
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt_f != '0) && (cnt_f <= swma_pkg::COUNT_W'(WINDOW)))
		else $error("held count out of range");

	// the mean can never be below the minimum
	a_mean_ge_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (mean_f >= min_scaled))
		else $error("mean below window minimum");

endmodule

bind sliding_window_min_and_average swma_checker #(.WINDOW(WINDOW)) u_swma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

[verif/tb_sliding_window_min_and_average.sv]
// Self-checking testbench for the sliding window min and average block.
`timescale 1ns / 1ps
module tb_sliding_window_min_and_average;

	localparam int WINDOW_LEN   = 10;
	localparam int DIRECTED_LEN = 25;
	localparam int RX_HOLD      = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 64;

	// bit positions of the result fields in m_tdata
	localparam int MIN_LSB = swma_pkg::MEAN_W;
	localparam int SUM_LSB = MIN_LSB + swma_pkg::SAMPLE_W;
	localparam int CNT_LSB = SUM_LSB + swma_pkg::SUM_W;

	typedef struct packed {
		swma_pkg::mean_t   mean_q8;
		swma_pkg::sample_t win_min;
		swma_pkg::sum_t    win_sum;
		swma_pkg::count_t  held;
	} window_result_t;

	typedef struct packed {
		logic              typed;
		swma_pkg::sample_t sample;
		window_result_t    want;
	} stim_row_t;

	// Directed samples; rows with typed set carry a hand-written expectation.
	localparam stim_row_t DIRECTED [DIRECTED_LEN] = '{
		// first sample after reset: mean is the sample itself
		'{1'b1, 16'sh7fff, '{24'sd8388352, 16'sh7fff, 22'sd32767, 7'd1}},
		'{1'b1, 16'sh8000, '{-24'sd128, 16'sh8000, -22'sd1, 7'd2}},
		'{1'b0, 16'sh8000, '0},
		'{1'b0, 16'sh8000, '0},
		'{1'b0, 16'sh8000, '0},
		'{1'b0, 16'sh8000, '0},
		'{1'b0, 16'sh8000, '0},
		'{1'b0, 16'sh8000, '0},
		'{1'b0, 16'sh8000, '0},
		'{1'b0, 16'sh8000, '0},
		// window full of the most negative sample: most negative mean and sum
		'{1'b1, 16'sh8000, '{24'sh800000, 16'sh8000, -22'sd327680, 7'd10}},
		'{1'b0, 16'sh7fff, '0},
		'{1'b0, 16'sh7fff, '0},
		'{1'b0, 16'sh7fff, '0},
		'{1'b0, 16'sh7fff, '0},
		'{1'b0, 16'sh7fff, '0},
		'{1'b0, 16'sh7fff, '0},
		'{1'b0, 16'sh7fff, '0},
		'{1'b0, 16'sh7fff, '0},
		'{1'b0, 16'sh7fff, '0},
		// old minimum has left the window: most positive mean and sum
		'{1'b1, 16'sh7fff, '{24'sd8388352, 16'sh7fff, 22'sd327670, 7'd10}},
		'{1'b0, 16'sh0000, '0},
		'{1'b0, 16'shffff, '0},
		'{1'b0, 16'sh0001, '0},
		'{1'b0, 16'sh0100, '0}
	};

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [swma_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [swma_pkg::OUT_TDATA_W-1:0] m_tdata;

	// window state mirrored by the predictor
	swma_pkg::sample_t win_ring [WINDOW_LEN];
	int                win_slot  = 0;
	int                win_fill  = 0;
	swma_pkg::sum_t    win_total = '0;

	window_result_t expected_windows [$];
	window_result_t got;
	window_result_t want_r;
	int             error_count  = 0;
	int             quiet_cycles = 0;
	int             stall_left   = 0;
	bit             tx_idle_en   = 1'b1;
	bit             rx_idle_en   = 1'b1;
	bit             hold_request = 1'b0;

	sliding_window_min_and_average #(
		.WINDOW(WINDOW_LEN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Push one sample into the mirrored window and return mean, min, sum, count.
	function automatic window_result_t predict_window(swma_pkg::sample_t s);
		window_result_t    r;
		swma_pkg::sample_t lowest;
		longint            scaled;
		if (win_fill >= WINDOW_LEN) begin
			win_total = win_total - win_ring[win_slot];
		end else begin
			win_fill++;
		end
		win_ring[win_slot] = s;
		win_total = win_total + s;
		win_slot = (win_slot + 1) % WINDOW_LEN;
		// only written slots are scanned
		lowest = win_ring[0];
		for (int i = 1; i < win_fill; i++) begin
			if (win_ring[i] < lowest) begin
				lowest = win_ring[i];
			end
		end
		// signed division truncates toward zero
		scaled = longint'(win_total) * (1 << swma_pkg::FRAC_W);
		r.mean_q8 = swma_pkg::mean_t'(scaled / win_fill);
		r.win_min = lowest;
		r.win_sum = win_total;
		r.held    = swma_pkg::count_t'(win_fill);
		return r;
	endfunction

	function automatic swma_pkg::sample_t random_sample();
		swma_pkg::sample_t s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				s = swma_pkg::sample_t'($urandom);
			end
			5, 6: begin
				s = swma_pkg::sample_t'(int'($urandom_range(0, 128)) - 64);
			end
			7: begin
				case ($urandom_range(0, 3))
					0: s = 16'sh7fff;
					1: s = 16'sh8000;
					2: s = 16'sh0000;
					default: s = 16'shffff;
				endcase
			end
			default: begin
				// clustered near one rail
				if ($urandom_range(0, 1) == 0) begin
					s = swma_pkg::sample_t'(32767 - int'($urandom_range(0, 255)));
				end else begin
					s = swma_pkg::sample_t'(-32768 + int'($urandom_range(0, 255)));
				end
			end
		endcase
		return s;
	endfunction

	function automatic void check_field(string name, longint want, longint seen);
		if (want != seen) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
			error_count++;
		end
	endfunction

	// Offer one sample from a falling edge; return at the falling edge after acceptance.
	task automatic send_sample(input swma_pkg::sample_t s, input logic typed,
	                           input window_result_t want);
		window_result_t r;
		s_tvalid <= 1'b1;
		s_tdata  <= s;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		r = predict_window(s);
		expected_windows.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic run_random(input int n);
		repeat (n) begin
			sender_gap();
			send_sample(random_sample(), 1'b0, '0);
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Reset and known input levels from time zero
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (RX_HOLD) @(negedge clk);
				stall_left = 0;
			end else if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_en && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 12);
				end
			end
		end
	end

	// Result checker and no-progress watchdog
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.mean_q8 = m_tdata[swma_pkg::MEAN_W-1:0];
			got.win_min = m_tdata[MIN_LSB +: swma_pkg::SAMPLE_W];
			got.win_sum = m_tdata[SUM_LSB +: swma_pkg::SUM_W];
			got.held    = m_tdata[CNT_LSB +: swma_pkg::COUNT_W];
			if (expected_windows.size() == 0) begin
				$display("%0t: result with none expected: mean %0d min %0d sum %0d count %0d",
					$time, got.mean_q8, got.win_min, got.win_sum, got.held);
				error_count++;
			end else begin
				want_r = expected_windows.pop_front();
				check_field("mean_q8", want_r.mean_q8, got.mean_q8);
				check_field("window_min", want_r.win_min, got.win_min);
				check_field("window_sum", want_r.win_sum, got.win_sum);
				check_field("held_count", want_r.held, got.held);
			end
		end
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("tb_sliding_window_min_and_average: FAIL");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		@(posedge arst_n);
		@(negedge clk);

		for (int i = 0; i < DIRECTED_LEN; i++) begin
			sender_gap();
			send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].want);
		end

		run_random(250);

		// long receiver hold-off while samples keep coming: input must back up
		hold_request = 1'b1;
		tx_idle_en   = 1'b0;
		run_random(20);

		// sender waits for every outstanding result
		s_tvalid <= 1'b0;
		do begin
			@(negedge clk);
		end while (expected_windows.size() != 0);

		// stretches with and without idling on each side
		for (int c = 0; c < 5; c++) begin
			tx_idle_en = (c % 2 == 0);
			rx_idle_en = (c % 3 != 1);
			run_random(30);
		end

		// closing stretch at full rate
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_random(100);
		s_tvalid <= 1'b0;

		while (expected_windows.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_sliding_window_min_and_average: PASS");
		end else begin
			$display("tb_sliding_window_min_and_average: FAIL");
		end
		$finish;
	end

endmodule
